// ----- design/fslt_pkg.sv -----
// Shared types, constants and arithmetic helpers for the four-sensor light tracker.
// Standalone package; used by four_sensor_light_tracker.
package fslt_pkg;

	// Widths fixed by the item and register formats
	localparam int LIGHT_W   = 10;
	localparam int ANGLE_W   = 8;
	localparam int INDEX_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;
	localparam int BAND_W    = 6;
	localparam int GAIN_W    = 4;

	// Default angle limit and reset values
	localparam int unsigned ANGLE_MAX_DEF = 180;
	localparam logic [ANGLE_W-1:0]    ANGLE_RESET     = 8'd90;
	localparam logic [LIGHT_W-1:0]    SPREAD_RESET    = 10'd50;
	localparam logic [BAND_W-1:0]     DB_PAN_RESET    = 6'd3;
	localparam logic [BAND_W-1:0]     DB_TILT_RESET   = 6'd2;

	// Proportional gains in tenths of a degree per unit of error
	localparam logic [GAIN_W-1:0] PAN_GAIN  = 4'd5;
	localparam logic [GAIN_W-1:0] TILT_GAIN = 4'd8;

	// A proportional step must stay below this many tenths
	localparam logic [9:0] STEP_LIMIT = 10'd200;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE    = 2'd0,
		REG_SPREAD  = 2'd1,
		REG_DB_PAN  = 2'd2,
		REG_DB_TILT = 2'd3
	} cfg_reg_t;

	// Tracking modes
	typedef enum logic {
		MODE_PROP = 1'b0,
		MODE_STEP = 1'b1
	} track_mode_t;

	// Axis error: (a - b + 512) * 40 / 1024 - 20, division truncating toward zero
	function automatic logic signed [6:0] axis_error(input logic [LIGHT_W-1:0] a,
			input logic [LIGHT_W-1:0] b);
		logic signed [11:0] x;
		logic signed [17:0] p;
		logic signed [17:0] q;
		x = $signed({2'b00, a}) - $signed({2'b00, b}) + 12'sd512;
		p = $signed({{6{x[11]}}, x}) * 18'sd40;
		// bias negative products so the shift rounds toward zero
		q = (p + (p[17] ? 18'sd1023 : 18'sd0)) >>> 10;
		axis_error = $signed(q[6:0]) - 7'sd20;
	endfunction

	// Proportional move of one axis, positions kept in tenths during the update
	function automatic logic [ANGLE_W-1:0] prop_move(input logic [ANGLE_W-1:0] pos,
			input logic signed [6:0] err, input logic [BAND_W-1:0] band,
			input logic [GAIN_W-1:0] gain, input logic [ANGLE_W-1:0] amax);
		logic [6:0]         mag;
		logic signed [10:0] step;
		logic [10:0]        step_mag;
		logic signed [12:0] cand;
		logic [11:0]        limit;
		logic [24:0]        quot;
		mag      = err[6] ? 7'(-err) : 7'(err);
		step     = $signed({{4{err[6]}}, err}) * $signed({7'b0, gain});
		step_mag = step[10] ? 11'(-step) : 11'(step);
		cand     = $signed({5'b0, pos}) * 13'sd10 - $signed({{2{step[10]}}, step});
		limit    = 12'(amax) * 12'd10;
		// cand / 10 for cand below 2560, by reciprocal multiply
		quot     = 25'(cand[11:0]) * 25'd6554;
		if (mag <= {1'b0, band})
			prop_move = pos;
		else if (step_mag < {1'b0, STEP_LIMIT} && !cand[12] && cand[11:0] <= limit)
			prop_move = quot[23:16];
		else
			prop_move = pos;
	endfunction

endpackage

// ----- design/four_sensor_light_tracker.sv -----
// Four-sensor light tracker: pan/tilt angle controller, top level.
// Depends on fslt_pkg for widths, register codes and the axis arithmetic.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat of four light readings.
//   Output channel (out_valid/out_ready) returns one beat per input beat: the
//   pan and tilt angles after the update, and the brightest and darkest sensor.
//   Configuration is written through cfg_write/cfg_index/cfg_data, one register
//   per cycle; the user must write only while no beat is in flight (not enforced).
// Timing:
//   A beat is registered in the input register on entry, and its result is
//   registered in the result register when the beat advances, so out_valid
//   rises once the beat has passed both registers. One beat per cycle is
//   sustained while out_ready stays high; the rate is set by the combinational
//   update of the stored angles between the input and result registers.
// Stall: when out_ready is low the result is held and the input register keeps
//   its beat; in_ready drops only when both registers are full.
// Reset: arst_n clears both stages, sets mode to proportional, the spread
//   threshold to 50, deadbands to 3 (pan) and 2 (tilt), both angles to 90.
module four_sensor_light_tracker #(
	parameter int unsigned ANGLE_MAX = fslt_pkg::ANGLE_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [fslt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fslt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fslt_pkg::LIGHT_W-1:0]      light_0,
	input  logic [fslt_pkg::LIGHT_W-1:0]      light_1,
	input  logic [fslt_pkg::LIGHT_W-1:0]      light_2,
	input  logic [fslt_pkg::LIGHT_W-1:0]      light_3,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fslt_pkg::ANGLE_W-1:0]      pan_angle,
	output logic [fslt_pkg::ANGLE_W-1:0]      tilt_angle,
	output logic [fslt_pkg::INDEX_W-1:0]      brightest_index,
	output logic [fslt_pkg::INDEX_W-1:0]      darkest_index
);
	import fslt_pkg::*;

	localparam logic [ANGLE_W-1:0] AMAX = ANGLE_W'(ANGLE_MAX);

	// Configuration registers
	track_mode_t        mode_q;
	logic [LIGHT_W-1:0] spread_q;
	logic [BAND_W-1:0]  db_pan_q;
	logic [BAND_W-1:0]  db_tilt_q;

	// Stored angles
	logic [ANGLE_W-1:0] pan_q;
	logic [ANGLE_W-1:0] tilt_q;

	// Input stage
	logic               valid_s1;
	logic [LIGHT_W-1:0] light_s1 [4];

	// Result stage
	logic               valid_s2;
	logic [ANGLE_W-1:0] pan_s2;
	logic [ANGLE_W-1:0] tilt_s2;
	logic [INDEX_W-1:0] bi_s2;
	logic [INDEX_W-1:0] di_s2;

	logic               advance;
	logic [INDEX_W-1:0] bi;
	logic [INDEX_W-1:0] di;
	logic [LIGHT_W-1:0] bv;
	logic [LIGHT_W-1:0] dv;
	logic signed [6:0]  err_pan;
	logic signed [6:0]  err_tilt;
	logic               pair_up;
	logic               pair_down;
	logic [ANGLE_W-1:0] pan_next;
	logic [ANGLE_W-1:0] tilt_next;

	// Move the input beat on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PROP;
			spread_q  <= SPREAD_RESET;
			db_pan_q  <= DB_PAN_RESET;
			db_tilt_q <= DB_TILT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:    mode_q    <= track_mode_t'(cfg_data[0]);
				REG_SPREAD:  spread_q  <= cfg_data;
				REG_DB_PAN:  db_pan_q  <= cfg_data[BAND_W-1:0];
				REG_DB_TILT: db_tilt_q <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			light_s1[0] <= light_0;
			light_s1[1] <= light_1;
			light_s1[2] <= light_2;
			light_s1[3] <= light_3;
		end
	end

	// Find brightest and darkest sensor, lowest index wins ties
	always_comb begin
		bi = '0;
		di = '0;
		bv = light_s1[0];
		dv = light_s1[0];
		for (int i = 1; i < 4; i++) begin
			if (light_s1[i] > bv) begin
				bv = light_s1[i];
				bi = INDEX_W'(i);
			end
			if (light_s1[i] < dv) begin
				dv = light_s1[i];
				di = INDEX_W'(i);
			end
		end
	end

	// Compute the next angles for both modes
	always_comb begin
		err_pan   = axis_error(light_s1[0], light_s1[1]);
		err_tilt  = axis_error(light_s1[3], light_s1[2]);
		pair_up   = (bi == 2'd3 && di == 2'd0) || (bi == 2'd1 && di == 2'd2);
		pair_down = (bi == 2'd2 && di == 2'd1) || (bi == 2'd0 && di == 2'd3);
		pan_next  = pan_q;
		tilt_next = tilt_q;
		if (mode_q == MODE_PROP) begin
			pan_next  = prop_move(pan_q, err_pan, db_pan_q, PAN_GAIN, AMAX);
			tilt_next = prop_move(tilt_q, err_tilt, db_tilt_q, TILT_GAIN, AMAX);
		end else if ((bv - dv) > spread_q) begin
			if (pair_up) begin
				pan_next  = (pan_q < AMAX) ? pan_q + 8'd1 : pan_q;
				tilt_next = (tilt_q != '0) ? tilt_q - 8'd1 : tilt_q;
			end else if (pair_down) begin
				pan_next  = (pan_q != '0) ? pan_q - 8'd1 : pan_q;
				tilt_next = (tilt_q < AMAX) ? tilt_q + 8'd1 : tilt_q;
			end
		end
	end

	// Update stored angles and the result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_q    <= ANGLE_RESET;
			tilt_q   <= ANGLE_RESET;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				pan_q  <= pan_next;
				tilt_q <= tilt_next;
			end
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	// Hold the result beat until it is taken
	always_ff @(posedge clk) begin
		if (advance) begin
			pan_s2  <= pan_next;
			tilt_s2 <= tilt_next;
			bi_s2   <= bi;
			di_s2   <= di;
		end
	end

	assign out_valid       = valid_s2;
	assign pan_angle       = pan_s2;
	assign tilt_angle      = tilt_s2;
	assign brightest_index = bi_s2;
	assign darkest_index   = di_s2;

`ifndef NO_ASSERTIONS
	// Angles change only when a beat moves into the result register
	a_angle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(pan_q) && $stable(tilt_q)))
		else $error("angle changed without an advancing beat");

	// Input must back-pressure when both stages are full and output stalls
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input accepted while pipeline full");

	// Stepping mode moves each axis by at most one degree; checked here for pan
	a_step_size: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_q == MODE_STEP) |=>
		(pan_q == $past(pan_q) || pan_q == $past(pan_q) + 8'd1
			|| pan_q == $past(pan_q) - 8'd1))
		else $error("stepping mode moved pan by more than one");

	// The result shown always matches the stored angles
	a_result_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (pan_s2 == pan_q && tilt_s2 == tilt_q))
		else $error("result angle differs from stored angle");
`endif

endmodule
